>>> sv/mcrf_pkg.sv
package mcrf_pkg;

  // fixed field widths of the word ports
  localparam int WORD_BITS = 32;
  localparam int CMD_W     = 3;
  localparam int CHAN_W    = 3;
  localparam int MASK_W    = 8;
  localparam int SEL_W     = 7;
  localparam int BASE_W    = 6;

  // defaults handed to the top level parameters
  localparam int CHANNELS_DEF   = 8;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [BASE_W-1:0] REG_BASE_RESET = 6'd2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TEST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SELECT = 3'd4;

  // result fields known at issue time; the data word follows from the store
  typedef struct packed {
    logic              use_word;
    logic [SEL_W-1:0]  sel_reg;
    logic              has_data;
    logic              error;
    logic [MASK_W-1:0] not_full;
    logic [MASK_W-1:0] consumed;
  } res_t;

endpackage

>>> sv/multi_channel_receive_fifo_rr_select.sv
// Bank of per-channel receive FIFOs with a round-robin channel select. Each input word carries
// one command: write appends in_word_in to a channel, read pops the oldest word, peek returns it
// without popping, test reports non-empty, and select picks, round robin from the channel after
// the last winner, a channel in in_channel_mask that holds data and reports its register number
// (cfg register_base plus channel). A write to a full FIFO, a read of an empty one or a select
// that finds nothing raises out_error and leaves all state untouched. Every result also carries
// the not-full mask and the consumed toggles as they stand after the command. The data words sit
// in one synchronous RAM of CHANNELS*FIFO_DEPTH entries; head pointers and fill counts are
// flops updated when a word is taken. A word taken into the issue stage moves on to the output
// register; a new word can be taken every cycle unless the issue stage holds, as it does while
// the output register is full and stalled. The RAM read of a pop or peek is issued at the taking
// edge and its data closes the result as the issue stage moves on. No clearing pass after reset:
// only written RAM entries are ever read. cfg writes are meant for idle periods only.
module multi_channel_receive_fifo_rr_select #(
  parameter int CHANNELS   = mcrf_pkg::CHANNELS_DEF,
  parameter int FIFO_DEPTH = mcrf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [mcrf_pkg::BASE_W-1:0]           cfg_wr_data,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mcrf_pkg::CMD_W-1:0]            in_cmd,
  input  logic [mcrf_pkg::CHAN_W-1:0]           in_channel,
  input  logic signed [mcrf_pkg::WORD_BITS-1:0] in_word_in,
  input  logic [mcrf_pkg::MASK_W-1:0]           in_channel_mask,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mcrf_pkg::WORD_BITS-1:0] out_word_out,
  output logic [mcrf_pkg::SEL_W-1:0]            out_selected_register,
  output logic                                  out_has_data,
  output logic                                  out_error,
  output logic [mcrf_pkg::MASK_W-1:0]           out_not_full_mask,
  output logic [mcrf_pkg::MASK_W-1:0]           out_consumed_toggles
);
  import mcrf_pkg::*;

  localparam int DEPTH  = CHANNELS * FIFO_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [BASE_W-1:0]    reg_base_r;
  logic                 s1_valid_r;
  res_t                 s1_res_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  res_t                 out_res_r;

  logic                 s1_adv;
  logic                 in_take;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  res_t                 issue_res;

  // issue stage moves on when the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_base_r <= REG_BASE_RESET;
    end else if (cfg_wr_en) begin
      reg_base_r <= cfg_wr_data;
    end
  end

  mcrf_ctrl #(
    .CHANNELS   (CHANNELS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_take),
    .cmd          (in_cmd),
    .channel      (in_channel),
    .word_in      (in_word_in),
    .channel_mask (in_channel_mask),
    .reg_base     (reg_base_r),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .res          (issue_res)
  );

  // read data register holds until the next read, which waits for the issue stage to move
  mcrf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // issue stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_res_r <= issue_res;
    end
    if (s1_adv) begin
      out_res_r  <= s1_res_r;
      out_word_r <= s1_res_r.use_word ? mem_rdata : '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_word_out          = out_word_r;
  assign out_selected_register = out_res_r.sel_reg;
  assign out_has_data          = out_res_r.has_data;
  assign out_error             = out_res_r.error;
  assign out_not_full_mask     = out_res_r.not_full;
  assign out_consumed_toggles  = out_res_r.consumed;

`ifndef SYNTH
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("issue stage overrun while output stalled");
  a_err_excl_has: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.error && out_res_r.has_data))
    else $error("error and has_data both set");
  a_err_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.error) |-> (out_word_r == '0))
    else $error("data word on a failed command");
  a_word_from_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && mem_re) |=> (s1_valid_r && s1_res_r.use_word))
    else $error("store read without a data result");
`endif

endmodule

>>> sv/mcrf_store.sv
module mcrf_store #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [mcrf_pkg::WORD_BITS-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [mcrf_pkg::WORD_BITS-1:0] rd_data
);
  import mcrf_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/mcrf_ctrl.sv
module mcrf_ctrl #(
  parameter int CHANNELS   = 8,
  parameter int FIFO_DEPTH = 4,
  parameter int ADDR_W     = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [mcrf_pkg::CMD_W-1:0]     cmd,
  input  logic [mcrf_pkg::CHAN_W-1:0]    channel,
  input  logic [mcrf_pkg::WORD_BITS-1:0] word_in,
  input  logic [mcrf_pkg::MASK_W-1:0]    channel_mask,
  input  logic [mcrf_pkg::BASE_W-1:0]    reg_base,
  output logic                           mem_we,
  output logic [ADDR_W-1:0]              mem_waddr,
  output logic [mcrf_pkg::WORD_BITS-1:0] mem_wdata,
  output logic                           mem_re,
  output logic [ADDR_W-1:0]              mem_raddr,
  output mcrf_pkg::res_t                 res
);
  import mcrf_pkg::*;

  localparam int CH_W  = $clog2(CHANNELS);
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int RR_W  = CH_W + 1;

  logic [PTR_W-1:0] head_r [CHANNELS];
  logic [CNT_W-1:0] cnt_r  [CHANNELS];
  logic [CH_W-1:0]  last_r;
  logic [MASK_W-1:0] consumed_r;

  logic [CH_W-1:0]     ch_idx;
  logic                ch_ok;
  logic [PTR_W-1:0]    head_sel;
  logic [CNT_W-1:0]    cnt_sel;
  logic                ready;
  logic                full;
  logic [SUM_W-1:0]    slot_sum;
  logic [PTR_W-1:0]    wr_slot;
  logic [PTR_W-1:0]    head_inc;
  logic                wr_ok;
  logic                rd_ok;
  logic                look_ok;
  logic [CHANNELS-1:0] mask_ext;
  logic [CHANNELS-1:0] rdy_vec;
  logic [CHANNELS-1:0] nf_vec;
  logic [CNT_W-1:0]    cnt_after;
  logic [RR_W-1:0]     rr_sum;
  logic [CH_W-1:0]     rr_idx;
  logic                found;
  logic [CH_W-1:0]     sel_ch;
  logic [MASK_W-1:0]   consumed_nxt;

  assign ch_idx   = CH_W'(channel);
  assign ch_ok    = 6'(channel) < 6'(CHANNELS);
  assign head_sel = head_r[ch_idx];
  assign cnt_sel  = cnt_r[ch_idx];
  assign ready    = ch_ok && (cnt_sel != '0);
  assign full     = cnt_sel == CNT_W'(FIFO_DEPTH);

  // tail slot: head plus fill, wrapped once
  assign slot_sum = SUM_W'(head_sel) + SUM_W'(cnt_sel);
  assign wr_slot  = (slot_sum >= SUM_W'(FIFO_DEPTH)) ?
                    PTR_W'(slot_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(slot_sum);
  assign head_inc = (head_sel == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(head_sel + 1'b1);

  assign wr_ok   = (cmd == CMD_WRITE) && ch_ok && !full;
  assign rd_ok   = (cmd == CMD_READ) && ready;
  assign look_ok = ((cmd == CMD_READ) || (cmd == CMD_PEEK)) && ready;

  assign mem_we    = accept && wr_ok;
  assign mem_waddr = ADDR_W'(ch_idx * FIFO_DEPTH) + ADDR_W'(wr_slot);
  assign mem_wdata = word_in;
  assign mem_re    = accept && look_ok;
  assign mem_raddr = ADDR_W'(ch_idx * FIFO_DEPTH) + ADDR_W'(head_sel);

  assign mask_ext = CHANNELS'(channel_mask);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      rdy_vec[c] = mask_ext[c] && (cnt_r[c] != '0);
    end
  end

  // round-robin search, starting after the last winner
  always_comb begin
    found  = 1'b0;
    sel_ch = '0;
    rr_sum = '0;
    rr_idx = '0;
    for (int k = 1; k <= CHANNELS; k++) begin
      rr_sum = RR_W'(last_r) + RR_W'(k);
      if (rr_sum >= RR_W'(CHANNELS)) begin
        rr_sum = rr_sum - RR_W'(CHANNELS);
      end
      rr_idx = CH_W'(rr_sum);
      if (!found && rdy_vec[rr_idx]) begin
        found  = 1'b1;
        sel_ch = rr_idx;
      end
    end
  end

  // not-full after this command
  always_comb begin
    cnt_after = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      cnt_after = cnt_r[c];
      if (CH_W'(c) == ch_idx && wr_ok) begin
        cnt_after = cnt_r[c] + 1'b1;
      end else if (CH_W'(c) == ch_idx && rd_ok) begin
        cnt_after = cnt_r[c] - 1'b1;
      end
      nf_vec[c] = cnt_after < CNT_W'(FIFO_DEPTH);
    end
  end

  assign consumed_nxt = rd_ok ? (consumed_r ^ (MASK_W'(1) << channel)) : consumed_r;

  always_comb begin
    res          = '0;
    res.not_full = MASK_W'(nf_vec);
    res.consumed = consumed_nxt;
    unique case (cmd)
      CMD_WRITE: begin
        res.error = !wr_ok;
      end
      CMD_READ: begin
        res.error    = !rd_ok;
        res.use_word = look_ok;
      end
      CMD_PEEK: begin
        res.use_word = look_ok;
      end
      CMD_TEST: begin
        res.has_data = ready;
      end
      CMD_SELECT: begin
        res.has_data = found;
        res.error    = !found;
        res.sel_reg  = found ? (SEL_W'(reg_base) + SEL_W'(sel_ch)) : '0;
      end
      default: begin
        res.error = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        head_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
      last_r     <= '0;
      consumed_r <= '0;
    end else if (accept) begin
      if (wr_ok) begin
        cnt_r[ch_idx] <= cnt_sel + 1'b1;
      end
      if (rd_ok) begin
        cnt_r[ch_idx]  <= cnt_sel - 1'b1;
        head_r[ch_idx] <= head_inc;
      end
      if ((cmd == CMD_SELECT) && found) begin
        last_r <= sel_ch;
      end
      consumed_r <= consumed_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sel <= CNT_W'(FIFO_DEPTH))
    else $error("fill count beyond depth");
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !full)
    else $error("store written on full channel");
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (cnt_sel != '0))
    else $error("store read on empty channel");
`endif

endmodule

>>> bench/tb_multi_channel_receive_fifo_rr_select.sv
module tb_multi_channel_receive_fifo_rr_select;
  import mcrf_pkg::*;

  // the block is built with its default sizes
  localparam int CHANNEL_COUNT = 8;
  localparam int DEPTH = 4;
  // cycles to let pass after the last result before touching the register
  localparam int SETTLE_CYCLES = 4;
  // long receiver hold-off that fills the block and stalls its input
  localparam int HOLD_OFF_CYCLES = 200;
  // generous upper bound on the whole run, in time units
  localparam int RUN_LIMIT = 2000000;

  // one result word as the checker expects it
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [SEL_W-1:0]     sel_reg;
    logic                 has_data;
    logic                 error;
    logic [MASK_W-1:0]    not_full;
    logic [MASK_W-1:0]    consumed;
  } fifo_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [BASE_W-1:0]           cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            in_cmd = '0;
  logic [CHAN_W-1:0]           in_channel = '0;
  logic signed [WORD_BITS-1:0] in_word_in = '0;
  logic [MASK_W-1:0]           in_channel_mask = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [WORD_BITS-1:0] out_word_out;
  logic [SEL_W-1:0]            out_selected_register;
  logic                        out_has_data;
  logic                        out_error;
  logic [MASK_W-1:0]           out_not_full_mask;
  logic [MASK_W-1:0]           out_consumed_toggles;

  // predicted state of the fifo bank
  logic [WORD_BITS-1:0] fifo_words [0:CHANNEL_COUNT-1][0:DEPTH-1];
  logic [1:0]           head_ptr [0:CHANNEL_COUNT-1];
  logic [2:0]           fill_count [0:CHANNEL_COUNT-1];
  logic [CHAN_W-1:0]    last_winner;
  logic [MASK_W-1:0]    consumed_bits;
  logic [BASE_W-1:0]    register_base;

  fifo_result_t expected_results [$];
  int mismatch_count = 0;

  // idle percentages of sender and receiver, and the hold-off counter
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;

  multi_channel_receive_fifo_rr_select dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_channel            (in_channel),
    .in_word_in            (in_word_in),
    .in_channel_mask       (in_channel_mask),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_word_out          (out_word_out),
    .out_selected_register (out_selected_register),
    .out_has_data          (out_has_data),
    .out_error             (out_error),
    .out_not_full_mask     (out_not_full_mask),
    .out_consumed_toggles  (out_consumed_toggles)
  );

  always #5 clk = ~clk;

  // state after reset, before anything is taken
  initial begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      head_ptr[c] = '0;
      fill_count[c] = '0;
    end
    last_winner = '0;
    consumed_bits = '0;
    register_base = REG_BASE_RESET;
  end

  // advance the predicted fifo bank by one command and return its result word
  function automatic fifo_result_t apply_fifo_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [CHAN_W-1:0] ch,
                                                      input logic [WORD_BITS-1:0] word,
                                                      input logic [MASK_W-1:0] mask);
    fifo_result_t r;
    logic [1:0] slot;
    logic [CHAN_W-1:0] c;
    logic found;
    r = '0;
    found = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        // a full fifo refuses the word and nothing moves
        if (fill_count[ch] < DEPTH) begin
          slot = head_ptr[ch] + fill_count[ch][1:0];
          fifo_words[ch][slot] = word;
          fill_count[ch] = fill_count[ch] + 3'd1;
        end else begin
          r.error = 1'b1;
        end
      end
      CMD_READ: begin
        // pop flips the channel's consumed toggle; empty pop is an error
        if (fill_count[ch] != 0) begin
          r.word = fifo_words[ch][head_ptr[ch]];
          head_ptr[ch] = head_ptr[ch] + 2'd1;
          fill_count[ch] = fill_count[ch] - 3'd1;
          consumed_bits[ch] = ~consumed_bits[ch];
        end else begin
          r.error = 1'b1;
        end
      end
      CMD_PEEK: begin
        // empty peek gives zero without an error
        if (fill_count[ch] != 0)
          r.word = fifo_words[ch][head_ptr[ch]];
      end
      CMD_TEST: begin
        r.has_data = (fill_count[ch] != 0);
      end
      CMD_SELECT: begin
        // round robin from the channel after the last winner, ending on it
        r.error = 1'b1;
        for (int k = 1; k <= CHANNEL_COUNT; k++) begin
          c = last_winner + CHAN_W'(k);
          if (!found && mask[c] && fill_count[c] != 0) begin
            found = 1'b1;
            last_winner = c;
            r.sel_reg = SEL_W'(register_base) + SEL_W'(c);
            r.has_data = 1'b1;
            r.error = 1'b0;
          end
        end
      end
      default: begin
        // undefined commands do nothing and raise no flag
      end
    endcase
    for (int i = 0; i < CHANNEL_COUNT; i++)
      r.not_full[i] = (fill_count[i] < DEPTH);
    r.consumed = consumed_bits;
    return r;
  endfunction

  // every word taken by the block gets its expected result queued
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(apply_fifo_command(in_cmd, in_channel, in_word_in,
                                                    in_channel_mask));
  end

  task report_mismatch(input string field, input logic [WORD_BITS-1:0] got,
                       input logic [WORD_BITS-1:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
    mismatch_count++;
  endtask

  // compare each result word taken from the block with the oldest expectation
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", out_word_out, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_word_out !== want.word)
          report_mismatch("word_out", out_word_out, want.word);
        if (out_selected_register !== want.sel_reg)
          report_mismatch("selected_register", out_selected_register, want.sel_reg);
        if (out_has_data !== want.has_data)
          report_mismatch("has_data", out_has_data, want.has_data);
        if (out_error !== want.error)
          report_mismatch("error", out_error, want.error);
        if (out_not_full_mask !== want.not_full)
          report_mismatch("not_full_mask", out_not_full_mask, want.not_full);
        if (out_consumed_toggles !== want.consumed)
          report_mismatch("consumed_toggles", out_consumed_toggles, want.consumed);
      end
    end
  end

  // receiver: a counted hold-off wins over the random stall
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // offer one word, with random idle cycles ahead of it, and wait until taken
  task send_word(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
                 input logic [WORD_BITS-1:0] word, input logic [MASK_W-1:0] mask);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_channel <= ch;
    in_word_in <= word;
    in_channel_mask <= mask;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // drop valid, wait out every expected result, then let the pipeline settle
  task wait_idle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_register_base(input logic [BASE_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    register_base = value;
  endtask

  // everything on empty fifos: peek and test give zero, pop and select fail
  task test_empty_fifo_cases;
    send_word(CMD_PEEK, 3'd0, '0, '0);
    send_word(CMD_TEST, 3'd0, '0, '0);
    send_word(CMD_READ, 3'd0, '0, '0);
    send_word(CMD_SELECT, 3'd0, '0, 8'hFF);
  endtask

  // fill channel 0 with extreme words, overflow it, then look and pop
  task test_fill_and_drain;
    send_word(CMD_WRITE, 3'd0, 32'h8000_0000, '0);
    send_word(CMD_WRITE, 3'd0, 32'h7FFF_FFFF, '0);
    send_word(CMD_WRITE, 3'd0, 32'hFFFF_FFFF, '0);
    send_word(CMD_WRITE, 3'd0, 32'h0000_0000, '0);
    send_word(CMD_WRITE, 3'd0, 32'h1234_5678, '0);
    send_word(CMD_PEEK, 3'd0, '0, '0);
    send_word(CMD_TEST, 3'd0, '0, '0);
    send_word(CMD_READ, 3'd0, '0, '0);
  endtask

  // rotation of the select pointer, wrap-around, masked-out and empty masks
  task test_select_rotation;
    send_word(CMD_WRITE, 3'd7, 32'hA5A5_A5A5, '0);
    send_word(CMD_WRITE, 3'd3, 32'h5A5A_5A5A, '0);
    send_word(CMD_SELECT, 3'd0, '0, 8'hFF);
    send_word(CMD_SELECT, 3'd0, '0, 8'hFF);
    send_word(CMD_SELECT, 3'd0, '0, 8'hFF);
    send_word(CMD_SELECT, 3'd0, '0, 8'h08);
    send_word(CMD_SELECT, 3'd0, '0, 8'h40);
    send_word(CMD_SELECT, 3'd0, '0, 8'h00);
  endtask

  task test_undefined_commands;
    for (int k = CMD_SELECT + 1; k < (1 << CMD_W); k++)
      send_word(CMD_W'(k), CHAN_W'($urandom), $urandom, MASK_W'($urandom));
  endtask

  // a select must report the channel offset by the new base
  task test_register_base(input logic [BASE_W-1:0] value);
    write_register_base(value);
    send_word(CMD_WRITE, 3'd5, $urandom, '0);
    send_word(CMD_SELECT, 3'd0, '0, 8'h20);
    send_word(CMD_READ, 3'd5, '0, '0);
  endtask

  // random commands, mostly on a few hot channels so fifos fill and empty
  task test_random_traffic(input int count);
    int taken;
    int pick;
    logic [CHAN_W-1:0] ch;
    logic [MASK_W-1:0] mask;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(99);
      ch = ($urandom_range(99) < 60) ? CHAN_W'($urandom_range(2)) : CHAN_W'($urandom);
      case ($urandom_range(9))
        0:       mask = '0;
        1, 2:    mask = '1;
        default: mask = MASK_W'($urandom);
      endcase
      if (pick < 35) begin
        send_word(CMD_WRITE, ch, $urandom, mask);
        taken++;
      end else if (pick < 60) begin
        send_word(CMD_READ, ch, $urandom, mask);
        taken++;
      end else if (pick < 70) begin
        send_word(CMD_PEEK, ch, $urandom, mask);
        taken++;
      end else if (pick < 80) begin
        send_word(CMD_TEST, ch, $urandom, mask);
        taken++;
      end else if (pick < 95) begin
        send_word(CMD_SELECT, ch, $urandom, mask);
        taken++;
      end else begin
        // ignored by the block, so not counted
        send_word(CMD_W'($urandom_range(CMD_SELECT + 1, (1 << CMD_W) - 1)), ch, $urandom,
                  mask);
      end
    end
  endtask

  task run_random_phase(input int tx_pct, input int rx_pct, input int count);
    write_register_base(BASE_W'($urandom));
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    test_random_traffic(count);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task test_backpressure;
    wait_idle();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    hold_left <= HOLD_OFF_CYCLES;
    test_random_traffic(40);
  endtask

  initial begin
    // synchronous reset held from the start, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_fifo_cases();
    test_fill_and_drain();
    test_select_rotation();
    test_undefined_commands();
    test_register_base(6'd63);
    test_register_base(6'd0);

    // no idling, sender idle, receiver stalling, both
    run_random_phase(0, 0, 320);
    run_random_phase(62, 0, 320);
    run_random_phase(0, 62, 320);
    run_random_phase(14, 14, 320);

    test_backpressure();
    wait_idle();

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog on a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
